// File: hdl/tkr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tkr_pkg
// shared types, constants and the extended key decode for the typematic
// repeat engine
// ---------------------------------------------------------------------------
package tkr_pkg;

   // number of key entries and the index width that addresses them
   localparam int unsigned KEY_COUNT = 256;
   localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);

   // field widths
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned ENTRY_W = STAMP_W + COUNT_W;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // register indexes
   localparam logic REG_INITIAL_DELAY   = 1'b0;
   localparam logic REG_REPEAT_INTERVAL = 1'b1;

   // register reset values
   localparam logic [DELAY_W-1:0] DELAY_RESET    = 16'd500;
   localparam logic [DELAY_W-1:0] INTERVAL_RESET = 16'd80;

   // scan code constants
   localparam logic [CODE_W-1:0]  BREAK_BIT   = 8'h80;
   localparam logic [STAMP_W-1:0] ELAPSED_SAT = 32'h7FFF_FFFF;

   typedef enum logic {
      CMD_KEY_EVENT = 1'b0,
      CMD_POLL      = 1'b1
   } cmd_type;

   // navigation and other keys that travel behind the e0 prefix
   function automatic logic key_is_extended(input logic [CODE_W-1:0] code);
      logic ext;
      unique case (code) inside
         8'h9C, 8'h9D, 8'hB5, 8'hB8, 8'hC7, 8'hC8, 8'hC9,
         8'hCB, 8'hCD, 8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'hD3: ext = 1'b1;
         default: ext = 1'b0;
      endcase
      return ext;
   endfunction

endpackage
`default_nettype wire

// File: hdl/tkr_key_encode.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tkr_key_encode
// turns a scan code and make/break flag into the emitted byte and the
// extended flag
// ---------------------------------------------------------------------------
module tkr_key_encode (
   input  wire logic [tkr_pkg::CODE_W-1:0] code,
   input  wire logic                       brk,
   output logic      [tkr_pkg::CODE_W-1:0] out_key,
   output logic                            extended
);

   logic [tkr_pkg::CODE_W-1:0] base_byte;

   always_comb begin
      extended  = tkr_pkg::key_is_extended(code);
      // extended keys drop into the lower half of the code space
      base_byte = extended ? (code - tkr_pkg::BREAK_BIT) : code;
      out_key   = brk ? (base_byte | tkr_pkg::BREAK_BIT) : base_byte;
   end

endmodule
`default_nettype wire

// File: hdl/typematic_key_repeat_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// typematic_key_repeat_core
// per-key typematic repeat engine: key events emit their byte and stamp or release keys, polls
// fire repeat makes once the hold time passes the delay or the interval
// ---------------------------------------------------------------------------
// flow: a taken request beat is captured into the evaluate stage, and its
//   result beat, if any, is then registered onto rsp_
// one request at a time: the entry memory read must land
//   before the same entry is modified and written back, so the next request
//   waits for the write
// reset: held bits cleared at once (no clearing pass), delay 500, interval 80
module typematic_key_repeat_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_command,
   input  wire logic [tkr_pkg::CODE_W-1:0]         req_key_code,
   input  wire logic                               req_pressed,
   input  wire logic [tkr_pkg::STAMP_W-1:0]        req_now_ms,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [tkr_pkg::CODE_W-1:0]         rsp_out_key,
   output logic                                    rsp_is_break,
   output logic                                    rsp_extended_key,
   output logic                                    rsp_is_repeat,
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tkr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tkr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [tkr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [tkr_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [tkr_pkg::DELAY_W-1:0] interval_ff, interval_in;
   logic                        csr_wr;
   logic                        csr_reg_sel;

   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite;
   // registers sit on word addresses, writes do not decode the byte offset
   assign csr_reg_sel = csr_paddr[2];

   always_comb begin
      delay_in    = delay_ff;
      interval_in = interval_ff;
      if (csr_wr) begin
         unique case (csr_reg_sel)
            tkr_pkg::REG_INITIAL_DELAY:   delay_in    = csr_pwdata[tkr_pkg::DELAY_W-1:0];
            tkr_pkg::REG_REPEAT_INTERVAL: interval_in = csr_pwdata[tkr_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= tkr_pkg::DELAY_RESET;
         interval_ff <= tkr_pkg::INTERVAL_RESET;
      end else begin
         delay_ff    <= delay_in;
         interval_ff <= interval_in;
      end
   end

   // readback: misaligned addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (csr_reg_sel)
            tkr_pkg::REG_INITIAL_DELAY:
               csr_prdata = {{(tkr_pkg::CSR_DATA_W-tkr_pkg::DELAY_W){1'b0}}, delay_ff};
            tkr_pkg::REG_REPEAT_INTERVAL:
               csr_prdata = {{(tkr_pkg::CSR_DATA_W-tkr_pkg::DELAY_W){1'b0}}, interval_ff};
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // request capture and entry memory read
   // ------------------------------------------------------------------
   logic                             req_fire;
   logic                             s1_valid_ff, s1_valid_in;
   tkr_pkg::cmd_type                 s1_cmd_ff;
   logic [tkr_pkg::CODE_W-1:0]       s1_key_ff;
   logic                             s1_pressed_ff;
   logic [tkr_pkg::STAMP_W-1:0]      s1_now_ff;
   logic                             s1_retire;

   // one request in flight at a time, so no read can overtake a pending write
   assign req_ready = !s1_valid_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_retire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= tkr_pkg::cmd_type'(req_command);
         s1_key_ff     <= req_key_code;
         s1_pressed_ff <= req_pressed;
         s1_now_ff     <= req_now_ms;
      end
   end

   // stamp and count live together in one entry: {count, stamp}
   logic [tkr_pkg::ENTRY_W-1:0]   entry_mem [tkr_pkg::KEY_COUNT];
   logic [tkr_pkg::ENTRY_W-1:0]   entry_rd_ff;
   logic                          entry_we;
   logic [tkr_pkg::ENTRY_W-1:0]   entry_wdata;
   logic [tkr_pkg::KEY_IDX_W-1:0] req_idx;
   logic [tkr_pkg::KEY_IDX_W-1:0] s1_idx;

   assign req_idx = req_key_code[tkr_pkg::KEY_IDX_W-1:0];
   assign s1_idx  = s1_key_ff[tkr_pkg::KEY_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         entry_rd_ff <= entry_mem[req_idx];
      end
      if (entry_we) begin
         entry_mem[s1_idx] <= entry_wdata;
      end
   end

   // held bits in flops so that reset clears them without a clearing pass
   logic [tkr_pkg::KEY_COUNT-1:0] held_ff, held_in;

   // ------------------------------------------------------------------
   // evaluate and write back
   // ------------------------------------------------------------------
   logic                          is_event;
   logic                          key_ok;
   logic                          held_now;
   logic [tkr_pkg::STAMP_W-1:0]   stamp;
   logic [tkr_pkg::COUNT_W-1:0]   count;
   logic [tkr_pkg::STAMP_W:0]     diff;
   logic [tkr_pkg::STAMP_W-1:0]   elapsed;
   logic [tkr_pkg::DELAY_W-1:0]   limit;
   logic                          fire;
   logic                          emit;
   logic                          emit_brk;

   assign is_event = (s1_cmd_ff == tkr_pkg::CMD_KEY_EVENT);
   // codes past the table emit on events but touch no state
   assign key_ok   = ({1'b0, s1_key_ff} < (tkr_pkg::CODE_W+1)'(tkr_pkg::KEY_COUNT));
   assign held_now = held_ff[s1_idx];
   assign stamp    = entry_rd_ff[tkr_pkg::STAMP_W-1:0];
   assign count    = entry_rd_ff[tkr_pkg::ENTRY_W-1:tkr_pkg::STAMP_W];

   always_comb begin
      // borrow out means the stamp lies ahead of now: saturate
      diff    = {1'b0, s1_now_ff} - {1'b0, stamp};
      elapsed = diff[tkr_pkg::STAMP_W] ? tkr_pkg::ELAPSED_SAT
                                       : diff[tkr_pkg::STAMP_W-1:0];
      // first repeat waits the initial delay, later ones the interval
      limit   = (count == '0) ? delay_ff : interval_ff;
      fire    = !is_event && key_ok && held_now
                && (elapsed > {{(tkr_pkg::STAMP_W-tkr_pkg::DELAY_W){1'b0}}, limit});
      emit    = is_event || fire;
      emit_brk = is_event && !s1_pressed_ff;
   end

   // finish the item once the output register is free or being drained
   assign s1_retire = s1_valid_ff && (!rsp_valid || rsp_ready);

   always_comb begin
      entry_we    = s1_retire && key_ok && ((is_event && s1_pressed_ff) || fire);
      // make clears the count, a repeat bumps it (wrapping)
      entry_wdata = is_event ? {{tkr_pkg::COUNT_W{1'b0}}, s1_now_ff}
                             : {count + 1'b1, s1_now_ff};
      held_in     = held_ff;
      if (s1_retire && key_ok && is_event) begin
         held_in[s1_idx] = s1_pressed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic [tkr_pkg::CODE_W-1:0] enc_key;
   logic                       enc_ext;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tkr_pkg::CODE_W-1:0] rsp_key_ff;
   logic                       rsp_break_ff;
   logic                       rsp_ext_ff;
   logic                       rsp_repeat_ff;

   tkr_key_encode u_encode (
      .code     (s1_key_ff),
      .brk      (emit_brk),
      .out_key  (enc_key),
      .extended (enc_ext)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_retire) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_retire && emit) begin
         rsp_key_ff    <= enc_key;
         rsp_break_ff  <= emit_brk;
         rsp_ext_ff    <= enc_ext;
         rsp_repeat_ff <= !is_event;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_is_break     = rsp_break_ff;
   assign rsp_extended_key = rsp_ext_ff;
   assign rsp_is_repeat    = rsp_repeat_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
`ifndef SYNTH
   // a taken request always occupies the evaluate stage next cycle
   a_fire_loads_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("request beat lost before evaluation");

   // a stalled item keeps its key until it retires
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_retire) |=> (s1_valid_ff && $stable(s1_key_ff)))
      else $error("evaluate stage changed while stalled");

   // repeats are always makes
   a_repeat_is_make: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_repeat_ff) |-> !rsp_break_ff)
      else $error("repeat beat flagged as break");

   // a repeat only fires for a held key
   a_fire_needs_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fire) |-> held_ff[s1_idx])
      else $error("repeat fired for a released key");
`endif

endmodule
`default_nettype wire
